// ===== src/roi_image_compare_core_defines.svh =====
// Assertion macros shared by the roi_image_compare_core RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ROI_IMAGE_COMPARE_CORE_DEFINES_SVH
`define ROI_IMAGE_COMPARE_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RIC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RIC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ric_pkg.sv =====
// Package for roi_image_compare_core: widths, register map, queue entry and config types,
// and the pixel distance function. No dependencies.
package ric_pkg;

	localparam int unsigned PIXEL_LIMIT = 16777216;
	localparam int unsigned CNT_W       = 25;
	localparam int unsigned FIELD_MAX   = (2 ** CNT_W) - 1;
	localparam logic [CNT_W-1:0] COUNT_CAP =
		CNT_W'((PIXEL_LIMIT < FIELD_MAX) ? PIXEL_LIMIT : FIELD_MAX);

	localparam int unsigned FRAC_W = 17;
	localparam logic [FRAC_W-1:0] Q16_ONE = FRAC_W'(65536);
	localparam int unsigned PROD_W = FRAC_W + CNT_W;

	// Register map, word index of each register.
	localparam int unsigned ADDR_W = 5;
	localparam logic [2:0] REG_BACKGROUND = 3'd0;
	localparam logic [2:0] REG_INK_THR    = 3'd1;
	localparam logic [2:0] REG_CHAN_TOL   = 3'd2;
	localparam logic [2:0] REG_MIN_INK    = 3'd3;
	localparam logic [2:0] REG_MAX_FRAC   = 3'd4;
	localparam logic [2:0] REG_MAX_COUNT  = 3'd5;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = QPTR_W + 1;

	typedef struct packed {
		logic [31:0]       background_color;
		logic [7:0]        ink_threshold;
		logic [7:0]        channel_tolerance;
		logic [CNT_W-1:0]  minimum_ink;
		logic [FRAC_W-1:0] max_changed_fraction;
		logic [CNT_W-1:0]  max_changed_count;
	} cfg_t;

	typedef struct packed {
		logic ink;
		logic changed;
		logic last;
	} entry_t;

	// Largest absolute difference over the four 8-bit channels.
	function automatic logic [7:0] pixel_distance(input logic [31:0] p, input logic [31:0] q);
		logic [7:0] best;
		logic [7:0] u;
		logic [7:0] v;
		logic [7:0] d;
		best = '0;
		for (int ch = 0; ch < 4; ch++) begin
			u = p[8*ch +: 8];
			v = q[8*ch +: 8];
			d = (u > v) ? (u - v) : (v - u);
			if (d > best) begin
				best = d;
			end
		end
		return best;
	endfunction

endpackage

// ===== src/ric_cfg.sv =====
// Configuration register bank of roi_image_compare_core on an APB-style port.
// Depends on ric_pkg.
module ric_cfg
	import ric_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.background_color     <= '0;
			cfg_q.ink_threshold        <= 8'd32;
			cfg_q.channel_tolerance    <= '0;
			cfg_q.minimum_ink          <= CNT_W'(1);
			cfg_q.max_changed_fraction <= '0;
			cfg_q.max_changed_count    <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_BACKGROUND: cfg_q.background_color     <= pwdata;
				REG_INK_THR:    cfg_q.ink_threshold        <= pwdata[7:0];
				REG_CHAN_TOL:   cfg_q.channel_tolerance    <= pwdata[7:0];
				REG_MIN_INK:    cfg_q.minimum_ink          <= pwdata[CNT_W-1:0];
				REG_MAX_FRAC:   cfg_q.max_changed_fraction <= pwdata[FRAC_W-1:0];
				REG_MAX_COUNT:  cfg_q.max_changed_count    <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BACKGROUND: prdata = cfg_q.background_color;
			REG_INK_THR:    prdata = 32'(cfg_q.ink_threshold);
			REG_CHAN_TOL:   prdata = 32'(cfg_q.channel_tolerance);
			REG_MIN_INK:    prdata = 32'(cfg_q.minimum_ink);
			REG_MAX_FRAC:   prdata = 32'(cfg_q.max_changed_fraction);
			REG_MAX_COUNT:  prdata = 32'(cfg_q.max_changed_count);
			default:        prdata = '0;
		endcase
	end

endmodule

// ===== src/ric_front.sv =====
// Front end of roi_image_compare_core: classifies each pixel pair as ink and/or changed.
// Depends on ric_pkg.
module ric_front
	import ric_pkg::*;
(
	input  logic [31:0] expected_pixel,
	input  logic [31:0] actual_pixel,
	input  logic        last_pixel,
	input  cfg_t        cfg,
	output entry_t      entry
);

	logic [7:0] exp_bg_dist;
	logic [7:0] act_bg_dist;
	logic [7:0] pair_dist;

	assign exp_bg_dist = pixel_distance(expected_pixel, cfg.background_color);
	assign act_bg_dist = pixel_distance(actual_pixel, cfg.background_color);
	assign pair_dist   = pixel_distance(expected_pixel, actual_pixel);

	assign entry.ink     = (exp_bg_dist > cfg.ink_threshold) ||
	                       (act_bg_dist > cfg.ink_threshold);
	assign entry.changed = pair_dist > cfg.channel_tolerance;
	assign entry.last    = last_pixel;

endmodule

// ===== src/ric_queue.sv =====
// Short queue of classified pixel words between the front and back ends.
// Depends on ric_pkg.
module ric_queue
	import ric_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  entry_t wr_entry,
	output logic   full,
	input  logic   rd_en,
	output logic   rd_valid,
	output entry_t rd_entry
);

	entry_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full     = cnt_q == QCNT_W'(QDEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_entry = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/ric_back.sv =====
// Back end of roi_image_compare_core: saturating counters and the verdict pipeline.
// Depends on ric_pkg and roi_image_compare_core_defines.svh.
`include "roi_image_compare_core_defines.svh"

module ric_back
	import ric_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             q_valid,
	input  entry_t           q_entry,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             compare_valid,
	output logic             images_equal,
	output logic             error_code,
	output logic [CNT_W-1:0] changed_pixels,
	output logic [CNT_W-1:0] ink_pixels
);

	logic [CNT_W-1:0]  ink_q;
	logic [CNT_W-1:0]  chg_q;
	logic [CNT_W-1:0]  ink_n;
	logic [CNT_W-1:0]  chg_n;

	logic              v_s1;
	logic [CNT_W-1:0]  ink_s1;
	logic [CNT_W-1:0]  chg_s1;

	logic              v_s2;
	logic [CNT_W-1:0]  ink_s2;
	logic [CNT_W-1:0]  chg_s2;
	logic              ok_s2;
	logic [PROD_W-1:0] prod_s2;

	logic              out_v_q;
	logic              valid_q;
	logic              equal_q;
	logic [CNT_W-1:0]  ink_out_q;
	logic [CNT_W-1:0]  chg_out_q;

	logic              adv_out;
	logic              adv_s2;
	logic              adv_s1;
	logic              pop_last;
	logic [FRAC_W-1:0] frac_clamped;
	logic [CNT_W-1:0]  denom;
	logic [PROD_W-1:0] scaled_chg;
	logic              equal_d;

	assign adv_out  = !out_v_q || !out_stall;
	assign adv_s2   = !v_s2 || adv_out;
	assign adv_s1   = !v_s1 || adv_s2;
	// A region end only leaves the queue when the verdict path has room for it.
	assign q_pop    = q_valid && (!q_entry.last || adv_s1);
	assign pop_last = q_pop && q_entry.last;

	assign ink_n = (q_entry.ink && (ink_q < COUNT_CAP)) ? ink_q + CNT_W'(1) : ink_q;
	assign chg_n = (q_entry.changed && (chg_q < COUNT_CAP)) ? chg_q + CNT_W'(1) : chg_q;

	assign frac_clamped = (cfg.max_changed_fraction > Q16_ONE) ? Q16_ONE
	                                                             : cfg.max_changed_fraction;
	assign denom        = (ink_s1 == '0) ? CNT_W'(1) : ink_s1;

	assign scaled_chg = PROD_W'({chg_s2, 16'b0});
	assign equal_d    = ok_s2 && (scaled_chg <= prod_s2) &&
	                    (chg_s2 <= cfg.max_changed_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ink_q   <= '0;
			chg_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pop_last) begin
				ink_q <= '0;
				chg_q <= '0;
			end else if (q_pop) begin
				ink_q <= ink_n;
				chg_q <= chg_n;
			end
			if (adv_s1) begin
				v_s1 <= pop_last;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_out) begin
				out_v_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pop_last) begin
			ink_s1 <= ink_n;
			chg_s1 <= chg_n;
		end
		if (adv_s2 && v_s1) begin
			ink_s2  <= ink_s1;
			chg_s2  <= chg_s1;
			ok_s2   <= ink_s1 >= cfg.minimum_ink;
			prod_s2 <= PROD_W'(frac_clamped) * PROD_W'(denom);
		end
		if (adv_out && v_s2) begin
			valid_q   <= ok_s2;
			equal_q   <= equal_d;
			ink_out_q <= ink_s2;
			chg_out_q <= chg_s2;
		end
	end

	assign out_valid      = out_v_q;
	assign compare_valid  = valid_q;
	assign images_equal   = equal_q;
	assign error_code     = !valid_q;
	assign changed_pixels = chg_out_q;
	assign ink_pixels     = ink_out_q;

	`RIC_ASSERT_IMP(a_ink_cap, 1'b1, (ink_q <= COUNT_CAP) && (chg_q <= COUNT_CAP), "counter above cap")
	`RIC_ASSERT_NXT(a_clear_after_last, pop_last, (ink_q == '0) && (chg_q == '0), "counters not cleared")
	`RIC_ASSERT_IMP(a_equal_needs_valid, out_v_q && images_equal, compare_valid, "equal without valid")
	`RIC_ASSERT_NXT(a_out_held, out_v_q && out_stall, out_v_q && $stable(chg_out_q) && $stable(equal_q), "stalled result changed")

endmodule

// ===== src/roi_image_compare_core.sv =====
// Top level of roi_image_compare_core: golden-image pixel comparison over a streamed region.
// Depends on ric_pkg, ric_cfg, ric_front, ric_queue and ric_back.

// The core takes one (expected, actual) pixel pair per clock unless out_stall fills the
// verdict path, and gives one result word per region when the pair marked last_pixel has
// been counted. The front end classifies each pair combinationally and writes it into a
// four-word queue; the back end pops one word per cycle into the saturating ink and changed
// counters, and that counter update loop sets the rate of one pair per clock. A region's
// verdict passes the count snapshot, ratio multiply and final compare registers after its
// last word is popped, and the verdict path runs alongside the counters, so the next region
// streams in meanwhile. in_stall rises only when the queue is full. Registers are written
// over the APB-style port and should be changed only while no region is in flight.
module roi_image_compare_core
	import ric_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [31:0]       expected_pixel,
	input  logic [31:0]       actual_pixel,
	input  logic              last_pixel,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              compare_valid,
	output logic              images_equal,
	output logic              error_code,
	output logic [CNT_W-1:0]  changed_pixels,
	output logic [CNT_W-1:0]  ink_pixels
);

	cfg_t   cfg;
	entry_t front_entry;
	entry_t q_entry;
	logic   q_full;
	logic   q_valid;
	logic   q_pop;
	logic   in_take;

	assign in_stall = q_full;
	assign in_take  = in_valid && !q_full;

	ric_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ric_front u_front (
		.expected_pixel (expected_pixel),
		.actual_pixel   (actual_pixel),
		.last_pixel     (last_pixel),
		.cfg            (cfg),
		.entry          (front_entry)
	);

	ric_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (in_take),
		.wr_entry (front_entry),
		.full     (q_full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_entry (q_entry)
	);

	ric_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.q_valid        (q_valid),
		.q_entry        (q_entry),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.compare_valid  (compare_valid),
		.images_equal   (images_equal),
		.error_code     (error_code),
		.changed_pixels (changed_pixels),
		.ink_pixels     (ink_pixels)
	);

endmodule

// ===== test/tb_roi_image_compare_core.sv =====
// Testbench for roi_image_compare_core: streams pixel-pair regions with random gaps and stalls,
// predicts each region's verdict and counts, and checks every result word in order.
// Depends on ric_pkg and the roi_image_compare_core RTL.
module tb_roi_image_compare_core;
	import ric_pkg::*;

	localparam longint unsigned FIELD_TOP = (64'd1 << CNT_W) - 1;
	localparam logic [CNT_W-1:0] SAT_LIMIT =
		CNT_W'((PIXEL_LIMIT < FIELD_TOP) ? PIXEL_LIMIT : FIELD_TOP);
	localparam longint unsigned Q16_UNITY = 65536;
	localparam logic ERR_NONE    = 1'b0;
	localparam logic ERR_LOW_INK = 1'b1;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 190;

	typedef struct packed {
		logic [31:0] golden;
		logic [31:0] captured;
		logic        last;
	} pixel_pair_t;

	typedef struct {
		logic             compare_valid;
		logic             images_equal;
		logic             error_code;
		logic [CNT_W-1:0] changed;
		logic [CNT_W-1:0] ink;
	} verdict_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [31:0]       expected_pixel = '0;
	logic [31:0]       actual_pixel = '0;
	logic              last_pixel = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              compare_valid;
	logic              images_equal;
	logic              error_code;
	logic [CNT_W-1:0]  changed_pixels;
	logic [CNT_W-1:0]  ink_pixels;

	// Register copies, at their reset values.
	logic [31:0]       bg_cfg = '0;
	logic [7:0]        ink_thr_cfg = 8'd32;
	logic [7:0]        tol_cfg = '0;
	logic [CNT_W-1:0]  min_ink_cfg = CNT_W'(1);
	logic [FRAC_W-1:0] frac_cfg = '0;
	logic [CNT_W-1:0]  max_count_cfg = '0;

	logic [CNT_W-1:0] ink_tally = '0;
	logic [CNT_W-1:0] changed_tally = '0;

	pixel_pair_t pixel_q[$];
	verdict_t    verdict_q[$];
	verdict_t    want;
	int          pixels_queued = 0;
	int          pixels_taken = 0;
	int          fail_count = 0;
	int          idle_odds = 5;
	int          send_gap = 0;
	int          stall_hold = 0;

	roi_image_compare_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.expected_pixel(expected_pixel),
		.actual_pixel(actual_pixel),
		.last_pixel(last_pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.compare_valid(compare_valid),
		.images_equal(images_equal),
		.error_code(error_code),
		.changed_pixels(changed_pixels),
		.ink_pixels(ink_pixels)
	);

	always #10 clk = ~clk;

	initial begin
		#(20 * 400000);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int channel_gap(input logic [31:0] a, input logic [31:0] b);
		int widest;
		int da;
		int db;
		widest = 0;
		for (int i = 0; i < 4; i++) begin
			da = int'(a[8*i +: 8]);
			db = int'(b[8*i +: 8]);
			if (da - db > widest) begin
				widest = da - db;
			end
			if (db - da > widest) begin
				widest = db - da;
			end
		end
		return widest;
	endfunction

	// Moves each channel by up to spread either way, clamped to the 8-bit range.
	function automatic logic [31:0] jitter_pixel(input logic [31:0] base, input int spread);
		logic [31:0] px;
		int c;
		for (int i = 0; i < 4; i++) begin
			c = int'(base[8*i +: 8]) + int'($urandom_range(0, 2 * spread)) - spread;
			if (c < 0) begin
				c = 0;
			end else if (c > 255) begin
				c = 255;
			end
			px[8*i +: 8] = c[7:0];
		end
		return px;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic tally_pixel(input logic [31:0] gold, input logic [31:0] capt,
		input logic last);
		verdict_t v;
		longint unsigned frac_lim;
		longint unsigned denom;
		if (channel_gap(gold, bg_cfg) > ink_thr_cfg || channel_gap(capt, bg_cfg) > ink_thr_cfg) begin
			if (ink_tally < SAT_LIMIT) begin
				ink_tally++;
			end
		end
		if (channel_gap(gold, capt) > tol_cfg) begin
			if (changed_tally < SAT_LIMIT) begin
				changed_tally++;
			end
		end
		if (last) begin
			v.changed = changed_tally;
			v.ink = ink_tally;
			if (ink_tally < min_ink_cfg) begin
				v.compare_valid = 1'b0;
				v.images_equal = 1'b0;
				v.error_code = ERR_LOW_INK;
			end else begin
				frac_lim = (frac_cfg > Q16_UNITY) ? Q16_UNITY : frac_cfg;
				denom = (ink_tally == 0) ? 1 : ink_tally;
				v.compare_valid = 1'b1;
				v.error_code = ERR_NONE;
				v.images_equal = (longint'(changed_tally) * Q16_UNITY <= frac_lim * denom) &&
					(changed_tally <= max_count_cfg);
			end
			verdict_q.push_back(v);
			ink_tally = '0;
			changed_tally = '0;
		end
	endtask

	// Input side: a new word goes out once the current one is taken or none is held.
	always @(posedge clk or negedge arst_n) begin
		pixel_pair_t p;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pixel_q.size() > 0) begin
				p = pixel_q.pop_front();
				in_valid <= 1'b1;
				expected_pixel <= p.golden;
				actual_pixel <= p.captured;
				last_pixel <= p.last;
				if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
					send_gap <= $urandom_range(1, 15);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_hold <= 0;
		end else if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
			out_stall <= 1'b1;
		end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			stall_hold <= $urandom_range(0, 14);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				tally_pixel(expected_pixel, actual_pixel, last_pixel);
				pixels_taken++;
			end
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("result word with no verdict pending");
				end else begin
					want = verdict_q.pop_front();
					if (compare_valid !== want.compare_valid)
						report_mismatch($sformatf("compare_valid %b, want %b",
							compare_valid, want.compare_valid));
					if (images_equal !== want.images_equal)
						report_mismatch($sformatf("images_equal %b, want %b",
							images_equal, want.images_equal));
					if (error_code !== want.error_code)
						report_mismatch($sformatf("error_code %b, want %b",
							error_code, want.error_code));
					if (changed_pixels !== want.changed)
						report_mismatch($sformatf("changed_pixels %0d, want %0d",
							changed_pixels, want.changed));
					if (ink_pixels !== want.ink)
						report_mismatch($sformatf("ink_pixels %0d, want %0d",
							ink_pixels, want.ink));
				end
			end
		end
	end

	task automatic queue_pixel(input logic [31:0] gold, input logic [31:0] capt,
		input logic last);
		pixel_q.push_back('{golden: gold, captured: capt, last: last});
		pixels_queued++;
	endtask

	// Waits until every queued word is taken and every verdict has come back.
	task automatic drain_traffic();
		while (pixels_taken != pixels_queued || verdict_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_BACKGROUND: bg_cfg = value;
			REG_INK_THR:    ink_thr_cfg = value[7:0];
			REG_CHAN_TOL:   tol_cfg = value[7:0];
			REG_MIN_INK:    min_ink_cfg = value[CNT_W-1:0];
			REG_MAX_FRAC:   frac_cfg = value[FRAC_W-1:0];
			REG_MAX_COUNT:  max_count_cfg = value[CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [31:0] bg, input int thr, input int tol,
		input int min_ink, input int frac, input int max_count);
		apb_write(REG_BACKGROUND, bg);
		apb_write(REG_INK_THR, thr);
		apb_write(REG_CHAN_TOL, tol);
		apb_write(REG_MIN_INK, min_ink);
		apb_write(REG_MAX_FRAC, frac);
		apb_write(REG_MAX_COUNT, max_count);
	endtask

	initial begin
		int len;
		int taken;
		logic [31:0] gold;
		logic [31:0] capt;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: a one-pixel region without ink, full-scale pairs, each channel alone just past
		// the ink threshold, and pixels sitting exactly on the threshold.
		queue_pixel(32'h0000_0000, 32'h0000_0000, 1'b1);
		queue_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		queue_pixel(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
		for (int ch = 0; ch < 4; ch++) begin
			queue_pixel(32'h21 << (8 * ch), 32'h0000_0000, ch == 3);
		end
		queue_pixel(32'h2020_2020, 32'h2020_2020, 1'b1);
		queue_pixel(32'h2020_2020, 32'h0000_0000, 1'b1);
		drain_traffic();

		// Tolerance edge, exact ratio of one half at the count limit, then too little ink,
		// then both limits broken.
		set_config(32'h8080_8080, 10, 5, 4, 32768, 2);
		queue_pixel(32'h8080_809F, 32'h8080_809F, 1'b0);
		queue_pixel(32'h8080_809F, 32'h8080_809A, 1'b0);
		queue_pixel(32'h8080_809F, 32'h8080_8099, 1'b0);
		queue_pixel(32'h0080_8080, 32'hFF80_8080, 1'b1);
		queue_pixel(32'h8080_8080, 32'h8080_8080, 1'b0);
		queue_pixel(32'h8080_809F, 32'h8080_809F, 1'b1);
		queue_pixel(32'h8080_FF80, 32'h8080_FF80, 1'b0);
		queue_pixel(32'h8080_FF80, 32'h8080_FF80, 1'b0);
		queue_pixel(32'h8080_FF80, 32'h8080_0080, 1'b0);
		queue_pixel(32'h8080_FF80, 32'h8080_0080, 1'b0);
		queue_pixel(32'h8080_FF80, 32'h8080_0080, 1'b1);
		drain_traffic();

		// Counter saturation needs more pixels than one run can afford, so it is not reached.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: set_config(32'h0000_0000, 0, 0, 0, 0, 0);
				1: set_config(32'hFFFF_FFFF, 255, 255, PIXEL_LIMIT, 131071, PIXEL_LIMIT);
				2: set_config($urandom(), $urandom_range(0, 60), $urandom_range(0, 30),
					$urandom_range(1, 4), $urandom_range(65537, 131071), PIXEL_LIMIT);
				default: set_config($urandom(), $urandom_range(0, 80), $urandom_range(0, 40),
					$urandom_range(0, 10), $urandom_range(0, 65536),
					($urandom_range(0, 3) == 0) ? PIXEL_LIMIT : $urandom_range(0, 30));
			endcase
			if (ph == RANDOM_PHASES - 1) begin
				idle_odds = 0;
			end else if (ph == 3) begin
				idle_odds = 40;
			end else begin
				idle_odds = $urandom_range(2, 10);
			end
			taken = 0;
			while (taken < PHASE_ITEMS) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 3) == 0) begin
						gold = $urandom();
					end else begin
						gold = jitter_pixel(bg_cfg, $urandom_range(0, ink_thr_cfg + 6));
					end
					case ($urandom_range(0, 3))
						0: capt = $urandom();
						1: capt = gold;
						default: capt = jitter_pixel(gold, $urandom_range(0, tol_cfg + 4));
					endcase
					queue_pixel(gold, capt, k == len - 1);
				end
				taken += len;
			end
			drain_traffic();
		end

		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/ric_pkg.sv
src/ric_cfg.sv
src/ric_front.sv
src/ric_queue.sv
src/ric_back.sv
src/roi_image_compare_core.sv
test/tb_roi_image_compare_core.sv
